>>> rtl/gph_pkg.sv
// Shared types and constants for the generational handle pool.
// Depends on nothing; the interfaces and the top level refer to it by scoped name.
package gph_pkg;

    localparam int DEF_CAPACITY  = 256;
    localparam int DEF_GEN_WIDTH = 32;
    localparam int GEN_INIT      = 1;

    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 16;
    localparam int HGEN_W  = 32;
    localparam int OIDX_W  = 8;
    localparam int OGEN_W  = 32;
    localparam int LIVE_W  = 9;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_CHECK = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_POP,
        ST_EVAL,
        ST_CLEAR,
        ST_HOLD
    } state_t;

endpackage

>>> rtl/gph_req_if.sv
// Request channel of the generational handle pool: valid, ready and one request.
// Depends on gph_pkg for the field widths.
interface gph_req_if;
    logic                             valid;
    logic                             ready;
    logic [gph_pkg::KIND_W-1:0]       kind;
    logic [gph_pkg::SLOT_W-1:0]       slot_index;
    logic [gph_pkg::HGEN_W-1:0]       handle_generation;

    modport source (output valid, kind, slot_index, handle_generation, input ready);
    modport sink   (input valid, kind, slot_index, handle_generation, output ready);
endinterface

>>> rtl/gph_rsp_if.sv
// Response channel of the generational handle pool: valid, ready and one result.
// Depends on gph_pkg for the field widths.
interface gph_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             ok;
    logic [gph_pkg::OIDX_W-1:0]       out_index;
    logic [gph_pkg::OGEN_W-1:0]       out_generation;
    logic [gph_pkg::LIVE_W-1:0]       live_count;

    modport source (output valid, ok, out_index, out_generation, live_count, input ready);
    modport sink   (input valid, ok, out_index, out_generation, live_count, output ready);
endinterface

>>> rtl/gph_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// Used for the slot table and the free stack; no dependencies.
module gph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/generational_handle_pool.sv
// Generational handle pool: top level with control sequencer and result register.
// Depends on gph_pkg, gph_req_if, gph_rsp_if and gph_ram.
//
// Usage
//   req carries one request per transfer: kind (alloc, free, check, clear),
//   slot_index and handle_generation. rsp returns exactly one result per
//   request, in order: ok, out_index, out_generation and live_count.
//   req.ready is high while the sequencer is idle; one request is in flight
//   at a time.
// Sequence, from request transfer to result register
//   free, check: slot read, then evaluation and write back
//   alloc: stack read, slot read, write back; on an empty stack no read or write, not ok
//   clear: one slot read-modify-write per cycle over every slot
//   A new request is taken once the sequencer is back in idle: as the result enters the
//   output register, or later from the hold state if that register is still full.
// Reset
//   After rst_n rises an initialisation pass writes every slot and stack
//   entry, during which req.ready stays low.
// Stall
//   A result waiting on rsp.ready does not block the next request; a second
//   finished result is held internally until the output register empties.
module generational_handle_pool #(
    parameter int CAPACITY  = gph_pkg::DEF_CAPACITY,
    parameter int GEN_WIDTH = gph_pkg::DEF_GEN_WIDTH
) (
    input  logic     clk,
    input  logic     rst_n,
    gph_req_if.sink  req,
    gph_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SLW   = GEN_WIDTH + 1;

    gph_pkg::state_t state_reg, state_next;
    gph_pkg::kind_t  kind_reg, kind_next;

    logic [IDX_W-1:0]     cnt_reg, cnt_next;
    logic                 rd_done_reg, rd_done_next;
    logic                 wr_pend_reg, wr_pend_next;
    logic [IDX_W-1:0]     wa_reg, wa_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 in_range_reg, in_range_next;
    logic [GEN_WIDTH-1:0] hgen_reg, hgen_next;
    logic [CNT_W-1:0]     depth_reg, depth_next;
    logic [CNT_W-1:0]     occ_reg, occ_next;

    logic                        out_valid_reg;
    logic                        out_ok_reg;
    logic [gph_pkg::OIDX_W-1:0]  out_idx_reg;
    logic [gph_pkg::OGEN_W-1:0]  out_gen_reg;
    logic [gph_pkg::LIVE_W-1:0]  out_live_reg;
    logic                        pend_ok_reg;
    logic [gph_pkg::OIDX_W-1:0]  pend_idx_reg;
    logic [gph_pkg::OGEN_W-1:0]  pend_gen_reg;
    logic [gph_pkg::LIVE_W-1:0]  pend_live_reg;

    logic                        res_valid;
    logic                        res_ok;
    logic [gph_pkg::OIDX_W-1:0]  res_idx;
    logic [gph_pkg::OGEN_W-1:0]  res_gen;
    logic [gph_pkg::LIVE_W-1:0]  res_live;

    logic             slot_we, slot_re;
    logic [IDX_W-1:0] slot_waddr, slot_raddr;
    logic [SLW-1:0]   slot_wdata, slot_rdata;
    logic             stk_we, stk_re;
    logic [IDX_W-1:0] stk_waddr, stk_raddr;
    logic [IDX_W-1:0] stk_wdata, stk_rdata;

    logic                 accept;
    logic                 out_free;
    logic                 clr_finish;
    logic                 slot_occ;
    logic [GEN_WIDTH-1:0] slot_gen;
    logic [GEN_WIDTH-1:0] gen_inc;
    logic                 handle_ok;
    logic [63:0]          hgen_ext;
    logic [63:0]          gen_ext;
    logic [CNT_W-1:0]     depth_m1;
    logic [31:0]          idx_ext;
    logic [31:0]          occ_ext;

    gph_ram #(.WIDTH(SLW), .DEPTH(CAPACITY)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    gph_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign req.ready  = (state_reg == gph_pkg::ST_IDLE);
    assign accept     = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign clr_finish = rd_done_reg && wr_pend_reg;

    assign slot_occ  = slot_rdata[GEN_WIDTH];
    assign slot_gen  = slot_rdata[GEN_WIDTH-1:0];
    assign gen_inc   = slot_gen + GEN_WIDTH'(1);
    assign handle_ok = in_range_reg && slot_occ && (slot_gen == hgen_reg);
    assign hgen_ext  = 64'(req.handle_generation);
    assign gen_ext   = 64'(slot_gen);
    assign depth_m1  = depth_reg - CNT_W'(1);
    assign idx_ext   = 32'(idx_reg);
    assign occ_ext   = 32'(occ_next);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gph_pkg::ST_INIT:
            begin
                if (cnt_reg == IDX_W'(CAPACITY - 1))
                begin
                    state_next = gph_pkg::ST_IDLE;
                end
            end
            gph_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (gph_pkg::kind_t'(req.kind))
                        gph_pkg::KIND_ALLOC:
                        begin
                            state_next = (depth_reg != '0) ? gph_pkg::ST_POP
                                                           : gph_pkg::ST_EVAL;
                        end
                        gph_pkg::KIND_FREE, gph_pkg::KIND_CHECK:
                        begin
                            state_next = gph_pkg::ST_EVAL;
                        end
                        gph_pkg::KIND_CLEAR:
                        begin
                            state_next = gph_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = gph_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            gph_pkg::ST_POP:
            begin
                state_next = gph_pkg::ST_EVAL;
            end
            gph_pkg::ST_EVAL:
            begin
                state_next = out_free ? gph_pkg::ST_IDLE : gph_pkg::ST_HOLD;
            end
            gph_pkg::ST_CLEAR:
            begin
                if (clr_finish)
                begin
                    state_next = out_free ? gph_pkg::ST_IDLE : gph_pkg::ST_HOLD;
                end
            end
            gph_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = gph_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gph_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        kind_next     = kind_reg;
        cnt_next      = cnt_reg;
        rd_done_next  = rd_done_reg;
        wr_pend_next  = wr_pend_reg;
        wa_next       = wa_reg;
        idx_next      = idx_reg;
        in_range_next = in_range_reg;
        hgen_next     = hgen_reg;
        depth_next    = depth_reg;
        occ_next      = occ_reg;

        slot_we    = 1'b0;
        slot_waddr = idx_reg;
        slot_wdata = {1'b0, slot_gen};
        slot_re    = 1'b0;
        slot_raddr = idx_reg;
        stk_we     = 1'b0;
        stk_waddr  = depth_reg[IDX_W-1:0];
        stk_wdata  = idx_reg;
        stk_re     = 1'b0;
        stk_raddr  = depth_m1[IDX_W-1:0];

        res_valid = 1'b0;
        res_ok    = 1'b0;
        res_idx   = '0;
        res_gen   = '0;

        unique case (state_reg)
            gph_pkg::ST_INIT:
            begin
                slot_we    = 1'b1;
                slot_waddr = cnt_reg;
                slot_wdata = {1'b0, GEN_WIDTH'(gph_pkg::GEN_INIT)};
                stk_we     = 1'b1;
                stk_waddr  = cnt_reg;
                stk_wdata  = cnt_reg;
                cnt_next   = cnt_reg + IDX_W'(1);
                if (cnt_reg == IDX_W'(CAPACITY - 1))
                begin
                    cnt_next   = '0;
                    depth_next = CNT_W'(CAPACITY);
                    occ_next   = '0;
                end
            end
            gph_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next     = gph_pkg::kind_t'(req.kind);
                    idx_next      = req.slot_index[IDX_W-1:0];
                    in_range_next = ({1'b0, req.slot_index} < 17'(CAPACITY));
                    hgen_next     = hgen_ext[GEN_WIDTH-1:0];
                    cnt_next      = '0;
                    rd_done_next  = 1'b0;
                    wr_pend_next  = 1'b0;
                    slot_raddr    = req.slot_index[IDX_W-1:0];
                    unique case (gph_pkg::kind_t'(req.kind))
                        gph_pkg::KIND_ALLOC:
                        begin
                            stk_re = (depth_reg != '0);
                        end
                        gph_pkg::KIND_FREE, gph_pkg::KIND_CHECK:
                        begin
                            slot_re = 1'b1;
                        end
                        default:
                        begin
                            slot_re = 1'b0;
                        end
                    endcase
                end
            end
            gph_pkg::ST_POP:
            begin
                idx_next   = stk_rdata;
                slot_re    = 1'b1;
                slot_raddr = stk_rdata;
            end
            gph_pkg::ST_EVAL:
            begin
                res_valid = 1'b1;
                unique case (kind_reg)
                    gph_pkg::KIND_ALLOC:
                    begin
                        if (depth_reg != '0)
                        begin
                            slot_we    = 1'b1;
                            slot_wdata = {1'b1, slot_gen};
                            depth_next = depth_m1;
                            occ_next   = occ_reg + CNT_W'(1);
                            res_ok     = 1'b1;
                            res_idx    = idx_ext[gph_pkg::OIDX_W-1:0];
                            res_gen    = gen_ext[gph_pkg::OGEN_W-1:0];
                        end
                    end
                    gph_pkg::KIND_FREE:
                    begin
                        if (handle_ok)
                        begin
                            slot_we    = 1'b1;
                            slot_wdata = {1'b0, gen_inc};
                            if (occ_reg != '0)
                            begin
                                occ_next = occ_reg - CNT_W'(1);
                            end
                            if (depth_reg < CNT_W'(CAPACITY))
                            begin
                                stk_we     = 1'b1;
                                depth_next = depth_reg + CNT_W'(1);
                            end
                            res_ok = 1'b1;
                        end
                    end
                    gph_pkg::KIND_CHECK:
                    begin
                        res_ok = handle_ok;
                    end
                    default:
                    begin
                        res_ok = 1'b0;
                    end
                endcase
            end
            gph_pkg::ST_CLEAR:
            begin
                if (!rd_done_reg)
                begin
                    slot_re    = 1'b1;
                    slot_raddr = cnt_reg;
                    cnt_next   = cnt_reg + IDX_W'(1);
                    if (cnt_reg == IDX_W'(CAPACITY - 1))
                    begin
                        rd_done_next = 1'b1;
                    end
                end
                wr_pend_next = !rd_done_reg;
                wa_next      = cnt_reg;
                if (wr_pend_reg)
                begin
                    slot_we    = 1'b1;
                    slot_waddr = wa_reg;
                    slot_wdata = {1'b0, slot_occ ? gen_inc : slot_gen};
                    stk_we     = 1'b1;
                    stk_waddr  = wa_reg;
                    stk_wdata  = wa_reg;
                end
                if (clr_finish)
                begin
                    depth_next = CNT_W'(CAPACITY);
                    occ_next   = '0;
                    res_valid  = 1'b1;
                    res_ok     = 1'b1;
                end
            end
            gph_pkg::ST_HOLD:
            begin
                res_valid = 1'b1;
                res_ok    = pend_ok_reg;
                res_idx   = pend_idx_reg;
                res_gen   = pend_gen_reg;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase

        res_live = occ_ext[gph_pkg::LIVE_W-1:0];
        if (state_reg == gph_pkg::ST_HOLD)
        begin
            res_live = pend_live_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gph_pkg::ST_INIT;
            kind_reg      <= gph_pkg::KIND_ALLOC;
            cnt_reg       <= '0;
            rd_done_reg   <= 1'b0;
            wr_pend_reg   <= 1'b0;
            depth_reg     <= CNT_W'(CAPACITY);
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            cnt_reg     <= cnt_next;
            rd_done_reg <= rd_done_next;
            wr_pend_reg <= wr_pend_next;
            depth_reg   <= depth_next;
            occ_reg     <= occ_next;
            if (res_valid && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wa_reg       <= wa_next;
        idx_reg      <= idx_next;
        in_range_reg <= in_range_next;
        hgen_reg     <= hgen_next;
        if (res_valid && out_free)
        begin
            out_ok_reg   <= res_ok;
            out_idx_reg  <= res_idx;
            out_gen_reg  <= res_gen;
            out_live_reg <= res_live;
        end
        if (res_valid && !out_free)
        begin
            pend_ok_reg   <= res_ok;
            pend_idx_reg  <= res_idx;
            pend_gen_reg  <= res_gen;
            pend_live_reg <= res_live;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.ok             = out_ok_reg;
    assign rsp.out_index      = out_idx_reg;
    assign rsp.out_generation = out_gen_reg;
    assign rsp.live_count     = out_live_reg;

    a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gph_pkg::ST_IDLE) |->
            (({1'b0, occ_reg} + {1'b0, depth_reg}) == (CNT_W + 1)'(CAPACITY)))
        else $error("live count and stack depth disagree");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= CNT_W'(CAPACITY))
        else $error("free stack depth beyond capacity");

    a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gph_pkg::ST_EVAL && kind_reg == gph_pkg::KIND_ALLOC &&
         depth_reg != '0) |-> !slot_occ)
        else $error("popped slot already occupied");

    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gph_pkg::ST_CLEAR && clr_finish) |=>
            (occ_reg == '0 && depth_reg == CNT_W'(CAPACITY)))
        else $error("clear left slots live");

    a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gph_pkg::ST_HOLD) |-> out_valid_reg)
        else $error("result held while output register empty");

endmodule
